/* src/scpa_pkg.sv */
// Shared types and constants of the size-class pool allocator.
// No dependencies; imported by the allocator top level, its port checker and the testbench.
package scpa_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 32;
   localparam int POOL_OUT_W = 3;
   localparam int STATUS_W = 2;

   // pool geometry, fixed for the project
   localparam int POOL_BYTES = 4096;
   localparam int POOL_SHIFT = $clog2(POOL_BYTES);
   localparam int HEADER_BYTES = 8;
   localparam int MIN_SIZE_LOG = 2;

   localparam int POOL_COUNT_DEFAULT = 8;
   localparam int MAX_BLOCKS_DEFAULT = 512;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd3;

   typedef struct packed {
      logic opcode;
      logic [SIZE_W-1:0] req_size;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      logic [POOL_OUT_W-1:0] pool_used;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASS,
      ST_DIVIDE,
      ST_ACCESS,
      ST_SCALE,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

/* src/size_class_pool_allocator_unit.sv */
// Size-class pool allocator: request decode, freed-slot stack memory and address math.
// Depends on scpa_pkg for the channel structs, status codes and pool geometry.
//
// Usage:
//   req_* carries allocate (req_size) and free (address) transactions, one result
//   per transaction on rsp_*. csr_* writes heap_base; it is always ready and must
//   only be written while no transaction is in flight.
//   One transaction is worked on at a time. Steps from acceptance to rsp_valid:
//     size too large ........ class decode
//     address outside heap .. pool decode, plus the reciprocal multiply when
//                               it falls in a pool's slack
//     free .................. pool decode, reciprocal multiply for the slot
//                               index, stack push
//     allocate .............. class decode, stack pop with its registered read,
//                               slot multiply, address add, unless the pool is empty
//   The next transaction is accepted in the cycle after the result is loaded
//   into the output register, even if the receiver has not taken it yet.
//   If rsp_ready stays low the finished result waits in its state until the
//   output register frees up; nothing is dropped.
//   Reset clears the stack depths, the fresh-slot counters and heap_base at once,
//   so there is no clearing pass. The stack memory itself is not cleared.
module size_class_pool_allocator_unit #(
   parameter int POOL_COUNT = scpa_pkg::POOL_COUNT_DEFAULT,
   parameter int MAX_BLOCKS = scpa_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  scpa_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output scpa_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scpa_pkg::ADDR_W-1:0]        csr_data
);
   import scpa_pkg::*;

   localparam int POOL_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);
   localparam int MEM_DEPTH = POOL_COUNT * MAX_BLOCKS;
   localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int WITHIN_W = POOL_SHIFT;
   localparam int MAX_SLOT = HEADER_BYTES + (1 << (MIN_SIZE_LOG + POOL_COUNT - 1));
   localparam int SLOT_W = $clog2(MAX_SLOT + 1);
   // within * slot < 2**RECIP_SHIFT keeps the reciprocal quotient exact
   localparam int RECIP_SHIFT = WITHIN_W + SLOT_W;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam longint HEAP_SPAN = longint'(POOL_COUNT) * POOL_BYTES;

   // per-pool constant tables
   logic [SIZE_W-1:0]  block_tab [POOL_COUNT];
   logic [SLOT_W-1:0]  slot_tab  [POOL_COUNT];
   logic [DEPTH_W-1:0] count_tab [POOL_COUNT];
   logic [RECIP_W-1:0] recip_tab [POOL_COUNT];

   for (genvar g = 0; g < POOL_COUNT; g++) begin : g_pool
      localparam longint BlockB = longint'(1) << (MIN_SIZE_LOG + g);
      localparam longint SlotB = HEADER_BYTES + BlockB;
      localparam longint Fit = POOL_BYTES / SlotB;
      localparam longint Cnt = (Fit > MAX_BLOCKS) ? MAX_BLOCKS : Fit;
      localparam longint Recip = ((longint'(1) << RECIP_SHIFT) / SlotB) + 1;
      assign block_tab[g] = SIZE_W'(BlockB);
      assign slot_tab[g]  = SLOT_W'(SlotB);
      assign count_tab[g] = DEPTH_W'(Cnt);
      assign recip_tab[g] = RECIP_W'(Recip);
   end

   state_type state_ff, state_in;

   logic                  op_ff, op_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [POOL_W-1:0]     pool_ff, pool_in;
   logic [WITHIN_W-1:0]   within_ff, within_in;
   logic [WITHIN_W-1:0]   quo_ff, quo_in;
   logic [DEPTH_W-1:0]    idx_ff, idx_in;
   logic                  from_stack_ff, from_stack_in;
   logic [POOL_SHIFT-1:0] scaled_ff, scaled_in;
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic [POOL_W-1:0]     res_pool_ff, res_pool_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [ADDR_W-1:0]     heap_base_ff, heap_base_in;
   logic [DEPTH_W-1:0]    depth_ff [POOL_COUNT];
   logic [DEPTH_W-1:0]    depth_in [POOL_COUNT];
   logic [DEPTH_W-1:0]    fresh_ff [POOL_COUNT];
   logic [DEPTH_W-1:0]    fresh_in [POOL_COUNT];

   // freed-slot stacks, MAX_BLOCKS entries per pool
   logic [IDX_W-1:0]      stack_mem [MEM_DEPTH];
   logic [IDX_W-1:0]      rd_data_ff;
   logic                  mem_rd_en;
   logic                  mem_wr_en;
   logic [MEM_AW-1:0]     stack_addr;
   logic [IDX_W-1:0]      mem_wr_data;

   logic [ADDR_W-1:0]     heap_off;
   logic [POOL_W-1:0]     fit_pool;
   logic                  fit_found;
   logic [DEPTH_W-1:0]    cur_depth;
   logic [DEPTH_W-1:0]    cur_fresh;
   logic [DEPTH_W-1:0]    stack_ptr;
   logic [IDX_W-1:0]      sel_idx;
   logic [IDX_W+SLOT_W-1:0]     scale_prod;
   logic [WITHIN_W+RECIP_W-1:0] div_prod;
   logic                  rsp_load;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // smallest class whose block holds the request
   always_comb begin
      fit_pool  = '0;
      fit_found = 1'b0;
      for (int g = POOL_COUNT - 1; g >= 0; g--) begin
         if (size_ff <= block_tab[g]) begin
            fit_pool  = POOL_W'(g);
            fit_found = 1'b1;
         end
      end
   end

   assign heap_off   = addr_ff - heap_base_ff;
   assign cur_depth  = depth_ff[pool_ff];
   assign cur_fresh  = fresh_ff[pool_ff];
   assign stack_ptr  = (op_ff == OP_FREE) ? cur_depth : DEPTH_W'(cur_depth - 1'b1);
   assign stack_addr = MEM_AW'(MEM_AW'(pool_ff) * MEM_AW'(MAX_BLOCKS)) + MEM_AW'(stack_ptr);
   assign mem_wr_data = IDX_W'(quo_ff);
   assign sel_idx    = from_stack_ff ? rd_data_ff : IDX_W'(idx_ff);
   assign scale_prod = (IDX_W+SLOT_W)'(sel_idx) * (IDX_W+SLOT_W)'(slot_tab[pool_ff]);
   assign div_prod   = (WITHIN_W+RECIP_W)'(within_ff) * (WITHIN_W+RECIP_W)'(recip_tab[pool_ff]);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      pool_in       = pool_ff;
      within_in     = within_ff;
      quo_in        = quo_ff;
      idx_in        = idx_ff;
      from_stack_in = from_stack_ff;
      scaled_in     = scaled_ff;
      res_addr_in   = res_addr_ff;
      res_pool_in   = res_pool_ff;
      res_status_in = res_status_ff;
      heap_base_in  = heap_base_ff;
      depth_in      = depth_ff;
      fresh_in      = fresh_ff;
      req_ready     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      rsp_load      = 1'b0;

      if (csr_valid) begin
         heap_base_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in         = req_data.opcode;
               size_in       = req_data.req_size;
               addr_in       = req_data.address;
               res_addr_in   = '0;
               res_pool_in   = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (op_ff == OP_ALLOC) begin
               pool_in = fit_pool;
               if (fit_found) begin
                  state_in = ST_ACCESS;
               end else begin
                  res_status_in = STATUS_TOO_LARGE;
                  state_in      = ST_DONE;
               end
            end else begin
               pool_in   = heap_off[POOL_SHIFT +: POOL_W];
               within_in = heap_off[WITHIN_W-1:0];
               if (longint'(heap_off) >= HEAP_SPAN) begin
                  res_status_in = STATUS_OUTSIDE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            quo_in   = div_prod[RECIP_SHIFT +: WITHIN_W];
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            if (op_ff == OP_FREE) begin
               state_in = ST_DONE;
               if (ADDR_W'(quo_ff) >= ADDR_W'(count_tab[pool_ff])) begin
                  // address in the slack past the pool's last slot
                  res_status_in = STATUS_OUTSIDE;
               end else begin
                  res_pool_in = pool_ff;
                  if (cur_depth < DEPTH_W'(MAX_BLOCKS)) begin
                     mem_wr_en         = 1'b1;
                     depth_in[pool_ff] = DEPTH_W'(cur_depth + 1'b1);
                  end
               end
            end else begin
               res_pool_in = pool_ff;
               if (cur_depth != '0) begin
                  mem_rd_en         = 1'b1;
                  from_stack_in     = 1'b1;
                  depth_in[pool_ff] = stack_ptr;
                  state_in          = ST_SCALE;
               end else if (cur_fresh < count_tab[pool_ff]) begin
                  from_stack_in     = 1'b0;
                  idx_in            = cur_fresh;
                  fresh_in[pool_ff] = DEPTH_W'(cur_fresh + 1'b1);
                  state_in          = ST_SCALE;
               end else begin
                  res_status_in = STATUS_EMPTY;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_SCALE: begin
            // slot offset inside the pool always stays below POOL_BYTES
            scaled_in = POOL_SHIFT'(scale_prod);
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            res_addr_in = heap_base_ff
                          + ((ADDR_W'(pool_ff) << POOL_SHIFT) | ADDR_W'(scaled_ff))
                          + ADDR_W'(HEADER_BYTES);
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.block_address = res_addr_ff;
         rsp_in.pool_used     = POOL_OUT_W'(res_pool_ff);
         rsp_in.status        = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         heap_base_ff <= '0;
         for (int p = 0; p < POOL_COUNT; p++) begin
            depth_ff[p] <= '0;
            fresh_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         heap_base_ff <= heap_base_in;
         depth_ff     <= depth_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      pool_ff       <= pool_in;
      within_ff     <= within_in;
      quo_ff        <= quo_in;
      idx_ff        <= idx_in;
      from_stack_ff <= from_stack_in;
      scaled_ff     <= scaled_in;
      res_addr_ff   <= res_addr_in;
      res_pool_ff   <= res_pool_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         stack_mem[stack_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= stack_mem[stack_addr];
      end
   end

endmodule

/* src/scpa_checker.sv */
// Port-level checks for the size-class pool allocator, bound to its top level.
// Depends on scpa_pkg for the result struct and status codes.
module scpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input scpa_pkg::rsp_type rsp_data
);
   import scpa_pkg::*;

   // transactions accepted but not yet delivered
   logic [1:0] cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 2'd0)
      else $error("result without an accepted request");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("more than two transactions in flight");

   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_TOO_LARGE || rsp_data.status == STATUS_OUTSIDE)
      |-> rsp_data.block_address == '0 && rsp_data.pool_used == '0)
      else $error("error result carries an address or pool");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind size_class_pool_allocator_unit scpa_checker u_scpa_checker (.*);

/* sim/tb_top.sv */
// Testbench for size_class_pool_allocator_unit: allocate and free transactions with random
// stalls on both channels, and heap_base moved between phases of traffic.
// Depends on scpa_pkg (channel structs, opcodes, status codes and pool geometry).
`timescale 1ns / 1ps

module tb_top;
   import scpa_pkg::*;

   localparam int NPOOL = POOL_COUNT_DEFAULT;
   localparam int STACK_SLOTS = MAX_BLOCKS_DEFAULT;
   localparam int HEAP_SPAN = NPOOL * POOL_BYTES;
   localparam int SETTLE_CYCLES = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SWEEP_ITEMS = 140;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [ADDR_W-1:0] csr_data;

   size_class_pool_allocator_unit #(
      .POOL_COUNT(NPOOL),
      .MAX_BLOCKS(STACK_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   // allocator state as the testbench sees it
   logic [ADDR_W-1:0] heap_base_model;
   int unsigned freed_slot [NPOOL][STACK_SLOTS];
   int unsigned stack_fill [NPOOL];
   int unsigned fresh_slot [NPOOL];

   rsp_type expected_rsp_q[$];
   logic [ADDR_W-1:0] live_block_off[$];
   rsp_type last_prediction;
   rsp_type want_rsp;

   bit stall_enable = 1'b1;
   bit idle_enable = 1'b1;
   int error_count = 0;
   int n_checked = 0;
   int n_alloc_ok = 0;
   int n_empty = 0;
   int n_too_large = 0;
   int n_free_ok = 0;
   int n_outside = 0;
   int n_base_writes = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint block_span(input int p);
      return longint'(1) << (MIN_SIZE_LOG + p);
   endfunction

   function automatic longint slot_span(input int p);
      return HEADER_BYTES + block_span(p);
   endfunction

   function automatic longint slots_per_pool(input int p);
      longint n;
      n = POOL_BYTES / slot_span(p);
      return (n > STACK_SLOTS) ? longint'(STACK_SLOTS) : n;
   endfunction

   function automatic rsp_type predict_allocator(input req_type item);
      rsp_type r;
      int p;
      longint idx;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] pool_off;
      bit served;
      r = '0;
      p = NPOOL;
      served = 1'b0;
      if (item.opcode == OP_ALLOC) begin
         for (int i = NPOOL - 1; i >= 0; i--)
            if (longint'(item.req_size) <= block_span(i)) p = i;
         if (p == NPOOL) begin
            r.status = STATUS_TOO_LARGE;
            n_too_large++;
         end else begin
            r.pool_used = p[POOL_OUT_W-1:0];
            if (stack_fill[p] > 0) begin
               stack_fill[p]--;
               idx = freed_slot[p][stack_fill[p]];
               served = 1'b1;
            end else if (fresh_slot[p] < slots_per_pool(p)) begin
               idx = fresh_slot[p];
               fresh_slot[p]++;
               served = 1'b1;
            end
            if (served) begin
               r.status = STATUS_OK;
               r.block_address = heap_base_model + 32'(p * POOL_BYTES)
                                 + 32'(idx * slot_span(p)) + 32'(HEADER_BYTES);
               n_alloc_ok++;
            end else begin
               r.status = STATUS_EMPTY;
               n_empty++;
            end
         end
      end else begin
         // offset wraps modulo 2^32, so addresses below the base land far outside
         off = item.address - heap_base_model;
         if (off >= HEAP_SPAN) begin
            r.status = STATUS_OUTSIDE;
            n_outside++;
         end else begin
            p = int'(off >> POOL_SHIFT);
            pool_off = off % POOL_BYTES;
            idx = longint'(pool_off) / slot_span(p);
            if (idx >= slots_per_pool(p)) begin
               r.status = STATUS_OUTSIDE;
               n_outside++;
            end else begin
               // a full stack silently drops the freed slot
               if (stack_fill[p] < STACK_SLOTS) begin
                  freed_slot[p][stack_fill[p]] = int'(idx);
                  stack_fill[p]++;
               end
               r.pool_used = p[POOL_OUT_W-1:0];
               r.status = STATUS_OK;
               n_free_ok++;
            end
         end
      end
      return r;
   endfunction

   task automatic report_error(input string what);
      if (error_count < 10) $display("%0t ERROR %s", $time, what);
      error_count++;
   endtask

   task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
      req_type item;
      item.opcode = op;
      item.req_size = size;
      item.address = addr;
      @(negedge clock);
      last_prediction = predict_allocator(item);
      expected_rsp_q.push_back(last_prediction);
      if (op == OP_ALLOC && last_prediction.status == STATUS_OK)
         live_block_off.push_back(last_prediction.block_address - heap_base_model);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_heap_base(input logic [ADDR_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      heap_base_model = value;
      n_base_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // half allocations, half frees: mostly of blocks handed out earlier, plus stray and wild addresses
   task automatic random_request();
      int pick;
      int k;
      int p;
      logic [ADDR_W-1:0] off;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(0, 99);
      size = $urandom;
      addr = $urandom;
      if (pick < 50) begin
         k = $urandom_range(0, 99);
         p = $urandom_range(0, NPOOL - 1);
         if (k < 85) begin
            size = $urandom_range(0, int'(block_span(p)));
         end else if (k < 95) begin
            if (size <= 512) size = size + 513;
         end else begin
            size = 32'(block_span(p)) + $urandom_range(0, 1);
         end
         send_request(OP_ALLOC, size, addr);
      end else begin
         if (pick < 80 && live_block_off.size() > 0) begin
            k = $urandom_range(0, live_block_off.size() - 1);
            off = live_block_off[k];
            live_block_off.delete(k);
            p = int'(off >> POOL_SHIFT);
            addr = heap_base_model + off - HEADER_BYTES
                   + $urandom_range(0, int'(slot_span(p)) - 1);
         end else if (pick < 90) begin
            addr = heap_base_model + $urandom_range(0, HEAP_SPAN - 1);
         end else if (pick < 94) begin
            addr = heap_base_model - $urandom_range(1, 64);
         end
         send_request(OP_FREE, size, addr);
      end
   endtask

   task automatic random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         // hold off until the pipeline is empty, then resume
         if (i == count / 2) drain_results();
         if (idle_enable && $urandom_range(0, 99) < 10) pause_sender($urandom_range(1, 13));
         random_request();
      end
   endtask

   task automatic test_directed_cases();
      logic [ADDR_W-1:0] pool0_blk;
      logic [ADDR_W-1:0] pool7_blk;
      send_request(OP_ALLOC, 32'd1, $urandom);
      send_request(OP_FREE, $urandom, last_prediction.block_address);
      write_heap_base(32'h0000_1000);
      send_request(OP_ALLOC, 32'd0, $urandom);
      send_request(OP_ALLOC, 32'd4, $urandom);
      pool0_blk = last_prediction.block_address;
      send_request(OP_ALLOC, 32'd5, $urandom);
      send_request(OP_ALLOC, 32'd256, $urandom);
      send_request(OP_ALLOC, 32'd257, $urandom);
      send_request(OP_ALLOC, 32'd513, $urandom);
      send_request(OP_ALLOC, 32'hFFFF_FFFF, $urandom);
      send_request(OP_ALLOC, 32'h8000_0000, $urandom);
      // the largest pool runs dry on the last of these
      for (int i = 0; i < 7; i++) begin
         send_request(OP_ALLOC, 32'd512, $urandom);
         if (i == 0) pool7_blk = last_prediction.block_address;
      end
      send_request(OP_FREE, $urandom, pool7_blk - HEADER_BYTES);
      send_request(OP_FREE, $urandom, pool0_blk + 3);
      send_request(OP_ALLOC, 32'd500, $urandom);
      send_request(OP_ALLOC, 32'd1, $urandom);
      send_request(OP_ALLOC, 32'd2, $urandom);
      send_request(OP_FREE, $urandom, heap_base_model - 1);
      send_request(OP_FREE, $urandom, heap_base_model + HEAP_SPAN);
      send_request(OP_FREE, $urandom, heap_base_model + (NPOOL - 1) * POOL_BYTES + 3700);
      send_request(OP_FREE, $urandom, 32'hFFFF_FFFF);
      send_request(OP_FREE, $urandom, heap_base_model + POOL_BYTES);
   endtask

   task automatic test_heap_base_sweep();
      logic [ADDR_W-1:0] bases [5];
      bases[0] = 32'hFFFF_FFFF;
      bases[1] = 32'hFFFF_9004;
      bases[2] = 32'h8000_0000;
      bases[3] = $urandom;
      bases[4] = 32'h0000_0000;
      foreach (bases[i]) begin
         write_heap_base(bases[i]);
         random_traffic(SWEEP_ITEMS);
      end
   endtask

   // overfill the largest pool's stack, then pop some of it back
   task automatic test_stack_overflow();
      int slot7;
      int count7;
      slot7 = int'(slot_span(NPOOL - 1));
      count7 = int'(slots_per_pool(NPOOL - 1));
      for (int i = 0; i < STACK_SLOTS + 4; i++) begin
         if (idle_enable && $urandom_range(0, 99) < 5) pause_sender($urandom_range(1, 13));
         send_request(OP_FREE, $urandom, heap_base_model + 32'((NPOOL - 1) * POOL_BYTES)
                      + 32'($urandom_range(0, count7 - 1) * slot7)
                      + $urandom_range(0, slot7 - 1));
      end
      for (int i = 0; i < 20; i++)
         send_request(OP_ALLOC, $urandom_range(257, 512), $urandom);
   endtask

   task automatic test_back_to_back();
      drain_results();
      stall_enable = 1'b0;
      idle_enable = 1'b0;
      random_traffic(200);
   endtask

   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_enable && $urandom_range(0, 99) < 6) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_checked++;
         if (expected_rsp_q.size() == 0) begin
            report_error($sformatf("unexpected result addr=%h pool=%0d status=%0d",
                                   rsp_data.block_address, rsp_data.pool_used, rsp_data.status));
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            if (rsp_data.block_address !== want_rsp.block_address ||
                rsp_data.pool_used !== want_rsp.pool_used ||
                rsp_data.status !== want_rsp.status)
               report_error($sformatf(
                  "result %0d: addr exp %h got %h, pool exp %0d got %0d, status exp %0d got %0d",
                  n_checked, want_rsp.block_address, rsp_data.block_address,
                  want_rsp.pool_used, rsp_data.pool_used, want_rsp.status, rsp_data.status));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      heap_base_model = '0;
      foreach (stack_fill[i]) begin
         stack_fill[i] = 0;
         fresh_slot[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_heap_base_sweep();
      test_stack_overflow();
      test_back_to_back();
      drain_results();

      if (expected_rsp_q.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_rsp_q.size()));
      $display("checked %0d results: %0d blocks handed out, %0d frees, %0d too large,",
               n_checked, n_alloc_ok, n_free_ok, n_too_large);
      $display("%0d empty pools, %0d addresses outside heap, %0d heap base writes, %0d errors",
               n_empty, n_outside, n_base_writes, error_count);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
